/* rtl/marked_day_set_window_core_macros.svh */
// assertion macros shared by the marked day set rtl
// expects clk and rst to be visible where a macro is used
`ifndef MARKED_DAY_SET_WINDOW_CORE_MACROS_SVH
`define MARKED_DAY_SET_WINDOW_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define MDSW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, off during reset
`define MDSW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/mdsw_pkg.sv */
// types, constants and helper functions for the marked day set window
// used by mdsw_ctrl, mdsw_datapath and marked_day_set_window_core
`default_nettype none

package mdsw_pkg;

  localparam int DEF_WINDOW_DAYS = 1024;
  localparam int KEY_W           = 21;
  localparam int COUNT_OUT_W     = 11;
  localparam int WORD_BITS       = 32;
  localparam int BIT_IDX_W       = 5;
  localparam int MODE_W          = 2;
  localparam int YEAR_W          = 12;
  localparam int MONTH_W         = 4;
  localparam int DAY_W           = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_TEST   = 2'd0,
    MODE_MARK   = 2'd1,
    MODE_UNMARK = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CALC,
    ST_SLOT,
    ST_READ,
    ST_MOD,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_SCAN_END,
    ST_CLEAR,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic accept;
    logic calc;
    logic slot;
    logic modify;
    logic sweep_wr;
    logic scan_rd;
    logic scan_end;
    logic make_empty;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic op_clear;
    logic op_scan;
    logic cnt_last;
    logic out_free;
  } status_t;

  function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_IDX_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [BIT_IDX_W-1:0] highest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (v[i]) idx = BIT_IDX_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [KEY_W-1:0] key_of(input logic [YEAR_W-1:0] y,
                                             input logic [MONTH_W-1:0] m,
                                             input logic [DAY_W-1:0] d);
    return KEY_W'({y, 8'b0}) + KEY_W'({y, 7'b0}) + KEY_W'({m, 5'b0}) + KEY_W'(d);
  endfunction

endpackage

`default_nettype wire

/* rtl/mdsw_ctrl.sv */
// sequencing state machine for the marked day set window
// depends on mdsw_pkg; drives commands into mdsw_datapath
`default_nettype none

module mdsw_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mdsw_pkg::status_t stat,
  output mdsw_pkg::cmd_t         cmd
);
  import mdsw_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_INIT: begin
        cmd.sweep_wr = 1'b1;
        if (stat.cnt_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = stat.op_clear ? ST_CLEAR : ST_SLOT;
      end
      ST_SLOT: begin
        cmd.slot   = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_MOD;
      end
      ST_MOD: begin
        cmd.modify = 1'b1;
        state_next = stat.op_scan ? ST_SCAN : ST_RESULT;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.cnt_last) state_next = ST_SCAN_WAIT;
      end
      ST_SCAN_WAIT: begin
        state_next = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        cmd.scan_end = 1'b1;
        state_next   = ST_RESULT;
      end
      ST_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        if (stat.cnt_last) begin
          cmd.make_empty = 1'b1;
          state_next     = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/mdsw_datapath.sv */
// datapath of the marked day set window: bitmap ring memory, extremes,
// count, word scan and output register; depends on mdsw_pkg and the macros header
`default_nettype none

`include "marked_day_set_window_core_macros.svh"

module mdsw_datapath #(
  parameter int WINDOW_DAYS = mdsw_pkg::DEF_WINDOW_DAYS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire mdsw_pkg::cmd_t                   cmd,
  output mdsw_pkg::status_t                     stat,
  input  wire logic [mdsw_pkg::MODE_W-1:0]      mode,
  input  wire logic [mdsw_pkg::YEAR_W-1:0]      year,
  input  wire logic [mdsw_pkg::MONTH_W-1:0]     month,
  input  wire logic [mdsw_pkg::DAY_W-1:0]       day_of_month,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  is_marked,
  output logic                                  status,
  output logic                                  set_empty,
  output logic [mdsw_pkg::KEY_W-1:0]            first_key,
  output logic [mdsw_pkg::KEY_W-1:0]            last_key,
  output logic [mdsw_pkg::COUNT_OUT_W-1:0]      marked_count
);
  import mdsw_pkg::*;

  localparam int NW = (WINDOW_DAYS + WORD_BITS - 1) / WORD_BITS;
  localparam int WW = (NW > 1) ? $clog2(NW) : 1;
  localparam int SW = WW + BIT_IDX_W;
  localparam int CW = $clog2(WINDOW_DAYS + 1);
  localparam logic [SW:0]      W_S       = (SW + 1)'(WINDOW_DAYS);
  localparam logic [KEY_W-1:0] W_K       = KEY_W'(WINDOW_DAYS);
  localparam logic [WW-1:0]    LAST_WORD = WW'(NW - 1);

  function automatic logic [SW-1:0] wrap(input logic [SW:0] x);
    logic [SW:0] r;
    r = (x >= W_S) ? (x - W_S) : x;
    return r[SW-1:0];
  endfunction

  // bitmap ring
  logic [WORD_BITS-1:0] mem [NW];
  logic [WORD_BITS-1:0] rdata;
  logic                 mem_we;
  logic [WW-1:0]        mem_wa;
  logic [WW-1:0]        mem_ra;
  logic [WORD_BITS-1:0] mem_wd;

  // set state
  logic [SW-1:0]    base;
  logic [KEY_W-1:0] earliest;
  logic [KEY_W-1:0] latest;
  logic             empty;
  logic [CW-1:0]    total;

  // item registers
  mode_t            op;
  logic [KEY_W-1:0] key;
  logic             below;
  logic             after;
  logic             in_span;
  logic             too_long;
  logic             hit_first;
  logic             hit_last;
  logic [SW-1:0]    off_q;
  logic [SW-1:0]    dlo_q;
  logic [SW-1:0]    slot_q;
  logic [SW:0]      wb_q;
  logic             res_marked;
  logic             res_status;

  // scan
  logic [WW-1:0]    cnt;
  logic             scan_pv;
  logic [WW-1:0]    scan_word;
  logic             found;
  logic [SW-1:0]    min_off;
  logic [SW-1:0]    max_off;
  logic [SW-1:0]    min_slot;

  // item evaluation
  logic             key_lt, key_gt, span_ok, long_lo, long_hi, too_long_c;
  logic [KEY_W-1:0] d_lo, d_hi, r_lo;
  logic [SW-1:0]    slot_a, slot_b;

  always_comb begin
    key_lt     = key < earliest;
    key_gt     = key > latest;
    span_ok    = !empty && !key_lt && !key_gt;
    d_lo       = earliest - key;
    d_hi       = key - earliest;
    r_lo       = latest - key;
    long_lo    = r_lo >= W_K;
    long_hi    = d_hi >= W_K;
    too_long_c = (op == MODE_MARK) && !empty && ((key_lt && long_lo) || (key_gt && long_hi));
    slot_a     = wrap({1'b0, base} + {1'b0, off_q});
    slot_b     = wrap({1'b0, base} + (W_S - {1'b0, dlo_q}));
  end

  // read-modify-write of the addressed word
  logic [BIT_IDX_W-1:0] bsel;
  logic                 cur;
  logic [WORD_BITS-1:0] onehot;
  logic                 mark_do;
  logic                 unmark_do;

  always_comb begin
    bsel      = slot_q[BIT_IDX_W-1:0];
    cur       = rdata[bsel];
    onehot    = WORD_BITS'(1) << bsel;
    mark_do   = (op == MODE_MARK) && !too_long;
    unmark_do = (op == MODE_UNMARK) && in_span;
  end

  always_comb begin
    mem_ra = cmd.scan_rd ? cnt : slot_q[SW-1:BIT_IDX_W];
    mem_we = 1'b0;
    mem_wa = slot_q[SW-1:BIT_IDX_W];
    mem_wd = mark_do ? (rdata | onehot) : (rdata & ~onehot);
    if (cmd.sweep_wr) begin
      mem_we = 1'b1;
      mem_wa = cnt;
      mem_wd = '0;
    end else if (cmd.modify) begin
      mem_we = mark_do || unmark_do;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata <= mem[mem_ra];
  end

  // per-word extremes of ring offsets
  logic [WW-1:0]        bw;
  logic [BIT_IDX_W-1:0] bb;
  logic [WORD_BITS-1:0] hi_mask, s_hi, s_lo;
  logic [BIT_IDX_W-1:0] idx_min, idx_max;
  logic                 min_lo, max_lo;
  logic [SW-1:0]        slot_min, slot_max, off_min, off_max;
  logic [SW:0]          wrap_min, wrap_max;
  logic                 any_set;

  always_comb begin
    bw = base[SW-1:BIT_IDX_W];
    bb = base[BIT_IDX_W-1:0];
    for (int b = 0; b < WORD_BITS; b++) begin
      hi_mask[b] = (scan_word > bw) || ((scan_word == bw) && (BIT_IDX_W'(b) >= bb));
    end
    s_hi    = rdata & hi_mask;
    s_lo    = rdata & ~hi_mask;
    any_set = |rdata;
    min_lo  = !(|s_hi);
    max_lo  = |s_lo;
    idx_min = min_lo ? lowest_set(s_lo) : lowest_set(s_hi);
    idx_max = max_lo ? highest_set(s_lo) : highest_set(s_hi);
    slot_min = {scan_word, idx_min};
    slot_max = {scan_word, idx_max};
    wrap_min = {1'b0, slot_min} + wb_q;
    wrap_max = {1'b0, slot_max} + wb_q;
    off_min  = min_lo ? wrap_min[SW-1:0] : (slot_min - base);
    off_max  = max_lo ? wrap_max[SW-1:0] : (slot_max - base);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= '0;
      earliest  <= '0;
      latest    <= '0;
      empty     <= 1'b1;
      total     <= '0;
      cnt       <= '0;
      scan_pv   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      scan_pv <= cmd.scan_rd;
      if (cmd.sweep_wr || cmd.scan_rd) begin
        cnt <= (cnt == LAST_WORD) ? '0 : cnt + WW'(1);
      end
      if (cmd.make_empty || (cmd.scan_end && !found)) begin
        base     <= '0;
        earliest <= '0;
        latest   <= '0;
        empty    <= 1'b1;
        total    <= '0;
      end else if (cmd.scan_end) begin
        if (hit_first) begin
          base     <= min_slot;
          earliest <= earliest + KEY_W'(min_off);
        end else begin
          latest <= earliest + KEY_W'(max_off);
        end
      end else if (cmd.modify) begin
        if (mark_do) begin
          if (!cur) total <= total + CW'(1);
          if (empty || below) base <= slot_q;
          if (empty) begin
            earliest <= key;
            latest   <= key;
            empty    <= 1'b0;
          end else if (below) begin
            earliest <= key;
          end else if (after) begin
            latest <= key;
          end
        end else if (unmark_do && cur) begin
          total <= total - CW'(1);
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op  <= mode_t'(mode);
      key <= key_of(year, month, day_of_month);
    end
    if (cmd.calc) begin
      below      <= key_lt;
      after      <= key_gt;
      in_span    <= span_ok;
      too_long   <= too_long_c;
      hit_first  <= (op == MODE_UNMARK) && span_ok && (key == earliest);
      hit_last   <= (op == MODE_UNMARK) && span_ok && (key == latest);
      off_q      <= d_hi[SW-1:0];
      dlo_q      <= d_lo[SW-1:0];
      res_marked <= 1'b0;
      res_status <= 1'b0;
    end
    if (cmd.slot) begin
      slot_q <= empty ? '0 : (below ? slot_b : slot_a);
    end
    if (cmd.scan_rd) begin
      scan_word <= cnt;
    end
    if (cmd.modify) begin
      res_marked <= (op == MODE_TEST) ? (in_span && cur) : mark_do;
      res_status <= too_long;
      found      <= 1'b0;
      wb_q       <= W_S - {1'b0, base};
    end else if (scan_pv && any_set) begin
      found <= 1'b1;
      if (!found || (off_min < min_off)) begin
        min_off  <= off_min;
        min_slot <= slot_min;
      end
      if (!found || (off_max > max_off)) begin
        max_off <= off_max;
      end
    end
    if (cmd.load_out) begin
      is_marked    <= res_marked;
      status       <= res_status;
      set_empty    <= empty;
      first_key    <= empty ? '0 : earliest;
      last_key     <= empty ? '0 : latest;
      marked_count <= COUNT_OUT_W'(total);
    end
  end

  always_comb begin
    stat.op_clear = (op == MODE_CLEAR);
    stat.op_scan  = hit_first || hit_last;
    stat.cnt_last = (cnt == LAST_WORD);
    stat.out_free = !out_valid || out_ready;
  end

  `MDSW_ASSERT_IMP(a_empty_clean, empty, (total == '0) && (earliest == '0) && (latest == '0))
  `MDSW_ASSERT_IMP(a_key_order, !empty, earliest <= latest)
  `MDSW_ASSERT_IMP(a_span_fits, !empty, (latest - earliest) < W_K)
  `MDSW_ASSERT_NXT(a_result_shown, cmd.load_out, out_valid)

endmodule

`default_nettype wire

/* rtl/marked_day_set_window_core.sv */
// Marked day set window. Test, mark and unmark of an inner day pass through the
// calc, slot, read, modify and result states; a new item is taken only in idle,
// once the last result is loaded. Unmarking the first or last mark adds a scan of
// the bitmap ring, one 32-bit word per cycle through the memory's single read port,
// over NW = ceil(WINDOW_DAYS / 32) words. Clear all sweeps the ring one word per cycle.
// After reset a clearing pass over every word runs with in_ready low. A new item is
// taken while the previous result still waits in the output register; a second
// finished result waits for that one to be taken.
// depends on mdsw_pkg, mdsw_ctrl and mdsw_datapath
`default_nettype none

module marked_day_set_window_core #(
  parameter int WINDOW_DAYS = mdsw_pkg::DEF_WINDOW_DAYS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [mdsw_pkg::MODE_W-1:0]      mode,
  input  wire logic [mdsw_pkg::YEAR_W-1:0]      year,
  input  wire logic [mdsw_pkg::MONTH_W-1:0]     month,
  input  wire logic [mdsw_pkg::DAY_W-1:0]       day_of_month,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  is_marked,
  output logic                                  status,
  output logic                                  set_empty,
  output logic [mdsw_pkg::KEY_W-1:0]            first_key,
  output logic [mdsw_pkg::KEY_W-1:0]            last_key,
  output logic [mdsw_pkg::COUNT_OUT_W-1:0]      marked_count
);
  import mdsw_pkg::*;

  cmd_t    cmd;
  status_t stat;

  mdsw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mdsw_datapath #(
    .WINDOW_DAYS (WINDOW_DAYS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .mode         (mode),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_marked    (is_marked),
    .status       (status),
    .set_empty    (set_empty),
    .first_key    (first_key),
    .last_key     (last_key),
    .marked_count (marked_count)
  );

endmodule

`default_nettype wire

/* verif/marked_day_set_window_core_tb.sv */
// self-checking testbench for marked_day_set_window_core: a directed table then random
// test, mark, unmark and clear items, each result checked against the table row or a bitmap ring predictor
// depends on mdsw_pkg and marked_day_set_window_core
`timescale 1ns / 100ps

module marked_day_set_window_core_tb;
  import mdsw_pkg::*;

  localparam int unsigned RING_DAYS  = DEF_WINDOW_DAYS;
  localparam int unsigned KEY_TOP    = 4095 * 384 + 11 * 32 + 31;
  localparam int unsigned RAND_ITEMS = 880;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned DRAIN_CYC  = 60;

  typedef struct packed {
    logic                   is_marked;
    logic                   status;
    logic                   set_empty;
    logic [KEY_W-1:0]       first_key;
    logic [KEY_W-1:0]       last_key;
    logic [COUNT_OUT_W-1:0] marked_count;
  } day_result_t;

  typedef struct {
    mode_t              mode;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    bit                 typed;
    day_result_t        want;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  mode_t                  mode_in;
  logic [YEAR_W-1:0]      year_in;
  logic [MONTH_W-1:0]     month_in;
  logic [DAY_W-1:0]       day_in;
  logic                   out_valid;
  logic                   out_ready;
  logic                   got_marked;
  logic                   got_status;
  logic                   got_empty;
  logic [KEY_W-1:0]       got_first;
  logic [KEY_W-1:0]       got_last;
  logic [COUNT_OUT_W-1:0] got_count;

  // predictor state
  bit [RING_DAYS-1:0] mark_ring;
  int unsigned        ring_base;
  int unsigned        first_mark;
  int unsigned        last_mark;
  bit                 set_is_empty;
  int unsigned        mark_count;

  day_result_t expected_days[$];
  stim_row_t   dir_rows[$];
  bit          row_typed;
  day_result_t row_want;
  int unsigned anchor_key;
  int unsigned fail_count;
  int unsigned results_seen;
  int unsigned idle_cycles;

  marked_day_set_window_core u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode_in),
    .year         (year_in),
    .month        (month_in),
    .day_of_month (day_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_marked    (got_marked),
    .status       (got_status),
    .set_empty    (got_empty),
    .first_key    (got_first),
    .last_key     (got_last),
    .marked_count (got_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned ring_slot(int unsigned off);
    return (ring_base + (off % RING_DAYS)) % RING_DAYS;
  endfunction

  function automatic void empty_days();
    mark_ring    = '0;
    ring_base    = 0;
    first_mark   = 0;
    last_mark    = 0;
    set_is_empty = 1'b1;
    mark_count   = 0;
  endfunction

  function automatic void write_slot(int unsigned s, bit v);
    if (v && !mark_ring[s]) mark_count++;
    if (!v && mark_ring[s]) mark_count--;
    mark_ring[s] = v;
  endfunction

  function automatic day_result_t apply_item(mode_t m, logic [YEAR_W-1:0] y,
                                             logic [MONTH_W-1:0] mo, logic [DAY_W-1:0] d);
    int unsigned k;
    int unsigned j;
    int unsigned span;
    bit          found;
    day_result_t r;
    k = 32'(y) * 384 + 32'(mo) * 32 + 32'(d);
    r = '0;
    found = 1'b0;
    case (m)
      MODE_CLEAR: empty_days();
      MODE_MARK: begin
        if (set_is_empty) begin
          ring_base    = 0;
          first_mark   = k;
          last_mark    = k;
          set_is_empty = 1'b0;
          write_slot(0, 1'b1);
        end else if (k < first_mark) begin
          if (last_mark - k + 1 > RING_DAYS) begin
            r.status = 1'b1;
          end else begin
            ring_base  = (ring_base + RING_DAYS - ((first_mark - k) % RING_DAYS)) % RING_DAYS;
            first_mark = k;
            write_slot(ring_base, 1'b1);
          end
        end else if (k > last_mark) begin
          if (k - first_mark + 1 > RING_DAYS) begin
            r.status = 1'b1;
          end else begin
            last_mark = k;
            write_slot(ring_slot(k - first_mark), 1'b1);
          end
        end else begin
          write_slot(ring_slot(k - first_mark), 1'b1);
        end
      end
      MODE_UNMARK: begin
        if (!set_is_empty && k >= first_mark && k <= last_mark) begin
          span = last_mark - first_mark + 1;
          write_slot(ring_slot(k - first_mark), 1'b0);
          if (k == first_mark) begin
            for (j = 1; j < span; j++) begin
              if (mark_ring[ring_slot(j)]) begin
                found = 1'b1;
                break;
              end
            end
            if (!found) begin
              empty_days();
            end else begin
              ring_base  = ring_slot(j);
              first_mark = first_mark + j;
            end
          end else if (k == last_mark) begin
            for (j = span - 1; j > 0; j--) begin
              if (mark_ring[ring_slot(j - 1)]) begin
                found = 1'b1;
                break;
              end
            end
            if (!found) empty_days();
            else last_mark = first_mark + (j - 1);
          end
        end
      end
      default: ;
    endcase
    if (!set_is_empty && k >= first_mark && k <= last_mark)
      r.is_marked = mark_ring[ring_slot(k - first_mark)];
    r.set_empty    = set_is_empty;
    r.first_key    = set_is_empty ? '0 : KEY_W'(first_mark);
    r.last_key     = set_is_empty ? '0 : KEY_W'(last_mark);
    r.marked_count = COUNT_OUT_W'(mark_count);
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    day_result_t want;
    day_result_t pred;
    bit          moved;
    moved = 1'b0;
    if (!rst && in_valid && in_ready) begin
      moved = 1'b1;
      pred = apply_item(mode_in, year_in, month_in, day_in);
      expected_days.insert(expected_days.size(), row_typed ? row_want : pred);
    end
    if (!rst && out_valid && out_ready) begin
      moved = 1'b1;
      results_seen++;
      if (expected_days.size() == 0) begin
        fail_count++;
        $display("%0t: result with no item pending, expected none, got first_key %0d",
                 $time, got_first);
      end else begin
        want = expected_days[0];
        expected_days.delete(0);
        check_field("is_marked", want.is_marked, got_marked);
        check_field("status", want.status, got_status);
        check_field("set_empty", want.set_empty, got_empty);
        check_field("first_key", want.first_key, got_first);
        check_field("last_key", want.last_key, got_last);
        check_field("marked_count", want.marked_count, got_count);
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // receiver: random stalls, one long hold after 150 results, a stretch with none
  initial begin
    int unsigned stall_left;
    int unsigned r;
    bit          hold_done;
    out_ready  = 1'b0;
    stall_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= 150) begin
        stall_left = 300;
        hold_done  = 1'b1;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        r = $urandom_range(0, 99);
        if (results_seen < 600 || results_seen >= 720) begin
          if (r < 15) stall_left = $urandom_range(1, 3);
          else if (r < 18) stall_left = $urandom_range(10, 60);
        end
      end
    end
  end

  function automatic int unsigned pick_gap(int unsigned idx);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (idx >= 400 && idx < 520) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly marks, unmarks and tests near the current span, some raw noise
  task automatic pick_random(output mode_t m, output logic [YEAR_W-1:0] y,
                             output logic [MONTH_W-1:0] mo, output logic [DAY_W-1:0] d);
    int unsigned sel;
    int unsigned k;
    int unsigned origin;
    sel    = $urandom_range(0, 999);
    origin = set_is_empty ? anchor_key : first_mark;
    k      = origin;
    m      = MODE_TEST;
    if (sel < 30) begin
      m  = mode_t'($urandom_range(0, 3));
      y  = YEAR_W'($urandom);
      mo = MONTH_W'($urandom);
      d  = DAY_W'($urandom);
    end else begin
      if (sel < 36) begin
        m = MODE_CLEAR;
        if ($urandom_range(0, 7) == 0) anchor_key = KEY_TOP - $urandom_range(0, 1200);
        else anchor_key = $urandom_range(0, KEY_TOP - 1200);
      end else if (sel < 530) begin
        m = MODE_MARK;
        k = origin + $urandom_range(0, 1100);
        if (k >= 30) k = k - 30;
      end else if (sel < 700) begin
        m = MODE_UNMARK;
        k = $urandom_range(0, 1) ? first_mark : last_mark;
      end else if (sel < 810) begin
        m = MODE_UNMARK;
        k = first_mark + $urandom_range(0, last_mark - first_mark);
      end else begin
        k = origin + $urandom_range(0, 1060);
        if (k >= 20) k = k - 20;
      end
      if (k > KEY_TOP) k = KEY_TOP;
      y  = YEAR_W'(k / 384);
      mo = MONTH_W'((k % 384) / 32);
      d  = DAY_W'(k % 32);
    end
  endtask

  task automatic offer_item(mode_t m, logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] mo,
                            logic [DAY_W-1:0] d);
    in_valid <= 1'b1;
    mode_in  <= m;
    year_in  <= y;
    month_in <= mo;
    day_in   <= d;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic idle_gap(int unsigned gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  initial begin
    mode_t              m;
    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] mo;
    logic [DAY_W-1:0]   d;
    int unsigned        n;
    rst          = 1'b1;
    in_valid     = 1'b0;
    mode_in      = MODE_TEST;
    year_in      = '0;
    month_in     = '0;
    day_in       = '0;
    row_typed    = 1'b0;
    row_want     = '0;
    anchor_key   = 5000;
    fail_count   = 0;
    results_seen = 0;
    idle_cycles  = 0;
    empty_days();

    dir_rows = '{
      '{MODE_TEST,   12'd0,    4'd1,  5'd1,  1'b1, '{1'b0, 1'b0, 1'b1, 21'd0, 21'd0, 11'd0}},
      '{MODE_MARK,   12'd4095, 4'd12, 5'd31, 1'b1,
        '{1'b1, 1'b0, 1'b0, 21'd1572895, 21'd1572895, 11'd1}},
      '{MODE_UNMARK, 12'd4095, 4'd12, 5'd31, 1'b1, '{1'b0, 1'b0, 1'b1, 21'd0, 21'd0, 11'd0}},
      '{MODE_MARK,   12'd0,    4'd0,  5'd0,  1'b1, '{1'b1, 1'b0, 1'b0, 21'd0, 21'd0, 11'd1}},
      '{MODE_MARK,   12'd10,   4'd1,  5'd1,  1'b1, '{1'b0, 1'b1, 1'b0, 21'd0, 21'd0, 11'd1}},
      '{MODE_MARK,   12'd2,    4'd7,  5'd31, 1'b1, '{1'b1, 1'b0, 1'b0, 21'd0, 21'd1023, 11'd2}},
      '{MODE_MARK,   12'd2,    4'd8,  5'd0,  1'b1, '{1'b0, 1'b1, 1'b0, 21'd0, 21'd1023, 11'd2}},
      '{MODE_UNMARK, 12'd0,    4'd0,  5'd0,  1'b0, '0},
      '{MODE_MARK,   12'd0,    4'd0,  5'd0,  1'b0, '0},
      '{MODE_MARK,   12'd0,    4'd15, 5'd31, 1'b0, '0},
      '{MODE_UNMARK, 12'd100,  4'd1,  5'd1,  1'b0, '0},
      '{MODE_UNMARK, 12'd0,    4'd15, 5'd31, 1'b0, '0},
      '{MODE_TEST,   12'd4095, 4'd15, 5'd31, 1'b0, '0},
      '{MODE_UNMARK, 12'd2,    4'd7,  5'd31, 1'b0, '0},
      '{MODE_TEST,   12'd0,    4'd0,  5'd0,  1'b0, '0},
      '{MODE_CLEAR,  12'd4095, 4'd15, 5'd31, 1'b1, '{1'b0, 1'b0, 1'b1, 21'd0, 21'd0, 11'd0}},
      '{MODE_UNMARK, 12'd0,    4'd1,  5'd1,  1'b1, '{1'b0, 1'b0, 1'b1, 21'd0, 21'd0, 11'd0}},
      '{MODE_MARK,   12'd4095, 4'd15, 5'd31, 1'b1,
        '{1'b1, 1'b0, 1'b0, 21'd1572991, 21'd1572991, 11'd1}},
      '{MODE_MARK,   12'd4095, 4'd15, 5'd26, 1'b0, '0},
      '{MODE_MARK,   12'd4095, 4'd15, 5'd30, 1'b0, '0},
      '{MODE_UNMARK, 12'd4095, 4'd15, 5'd31, 1'b0, '0},
      '{MODE_UNMARK, 12'd4095, 4'd15, 5'd26, 1'b0, '0},
      '{MODE_UNMARK, 12'd4095, 4'd15, 5'd30, 1'b0, '0},
      '{MODE_CLEAR,  12'd0,    4'd0,  5'd0,  1'b1, '{1'b0, 1'b0, 1'b1, 21'd0, 21'd0, 11'd0}}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      idle_gap(pick_gap(i));
      @(negedge clk);
      row_typed = dir_rows[i].typed;
      row_want  = dir_rows[i].want;
      offer_item(dir_rows[i].mode, dir_rows[i].year, dir_rows[i].month, dir_rows[i].day);
    end

    for (n = 0; n < RAND_ITEMS; n++) begin
      idle_gap(pick_gap(n));
      @(negedge clk);
      row_typed = 1'b0;
      pick_random(m, y, mo, d);
      offer_item(m, y, mo, d);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_days.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

/* marked_day_set_window_core.f */
+incdir+rtl
rtl/mdsw_pkg.sv
rtl/mdsw_ctrl.sv
rtl/mdsw_datapath.sv
rtl/marked_day_set_window_core.sv
verif/marked_day_set_window_core_tb.sv
